>>> sv/ipfwd_pkg.sv
// ----------------------------------------------------------------------------
// ipfwd_pkg: shared types and constants for the IPv4 forwarding decision
// Table sizes, opcodes, action codes, header length limits and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ipfwd_pkg;

	// Table sizes
	localparam int ROUTE_ENTRIES = 16;
	localparam int INTERFACES    = 4;

	localparam int RT_IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int IF_IDX_W = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;

	// Header length limits in bytes
	localparam int ETH_HDR_BYTES  = 14;
	localparam int IP_HDR_BYTES   = 20;
	localparam int ICMP_HDR_BYTES = 4;
	localparam logic [15:0] MIN_IP_LEN   = 16'(ETH_HDR_BYTES + IP_HDR_BYTES);
	localparam logic [15:0] MIN_ICMP_LEN = 16'(ETH_HDR_BYTES + IP_HDR_BYTES + ICMP_HDR_BYTES);

	localparam logic [7:0] PROTO_ICMP        = 8'd1;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

	typedef enum logic [1:0] {
		OP_ROUTE    = 2'd0,
		OP_IFACE    = 2'd1,
		OP_CLASSIFY = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE          = 3'd0,
		ACT_ECHO          = 3'd1,
		ACT_PORT_UNREACH  = 3'd2,
		ACT_TIME_EXCEEDED = 3'd3,
		ACT_NET_UNREACH   = 3'd4,
		ACT_FORWARD       = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_IF_SCAN,
		S_RT_SCAN,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;   // request accepted: write tables or latch packet
		logic if_step;   // check one interface address
		logic rt_step;   // check one route entry
		logic load_out;  // load the decision into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic classify;  // request at the input is a classify request
		logic pre_ok;    // length and header checksum pass
		logic is_local;  // destination matches a local interface
		logic ttl_low;   // ttl of 0 or 1
		logic if_last;   // interface scan at its last entry
		logic rt_last;   // route scan at its last entry
	} sts_t;

endpackage

>>> sv/ipfwd_ctrl.sv
// ----------------------------------------------------------------------------
// ipfwd_ctrl: sequencer for the forwarding decision
// Accepts requests, steps the interface and route scans, and hands the
// decision to the output register when it is free.
// ----------------------------------------------------------------------------
module ipfwd_ctrl
	import ipfwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid && sts.classify) begin
					state_d = S_IF_SCAN;
				end
			end
			S_IF_SCAN: begin
				cmd.if_step = 1'b1;
				if (sts.if_last) begin
					if (sts.pre_ok && !sts.is_local && !sts.ttl_low) begin
						state_d = S_RT_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RT_SCAN: begin
				cmd.rt_step = 1'b1;
				if (sts.rt_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("decision loaded over an untaken result");

	a_classify_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.classify) |=> (state_q == S_IF_SCAN))
		else $error("classify request did not start the interface scan");

	a_rt_not_local: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RT_SCAN) |-> !sts.is_local)
		else $error("route scan running for a local packet");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done state");

endmodule

>>> sv/ipfwd_dp.sv
// ----------------------------------------------------------------------------
// ipfwd_dp: tables, scan units and decision register
// Holds the route and interface tables, scans them one entry a cycle under
// controller command and forms the forwarding decision.
// ----------------------------------------------------------------------------
module ipfwd_dp
	import ipfwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [31:0] addr,
	input  logic [31:0] prefix_mask,
	input  logic [31:0] gateway,
	input  logic [1:0]  port,
	input  logic        entry_valid,
	input  logic [7:0]  ttl,
	input  logic [7:0]  protocol,
	input  logic [7:0]  icmp_kind,
	input  logic [15:0] packet_length,
	input  logic [1:0]  sum_flags,
	output logic [2:0]  action,
	output logic [1:0]  local_if,
	output logic [31:0] next_hop,
	output logic [1:0]  out_port,
	output logic [7:0]  new_ttl
);

	// Tables
	logic [31:0] route_dest_q [ROUTE_ENTRIES];
	logic [31:0] route_mask_q [ROUTE_ENTRIES];
	logic [31:0] route_gw_q   [ROUTE_ENTRIES];
	logic [1:0]  route_port_q [ROUTE_ENTRIES];
	logic [ROUTE_ENTRIES-1:0] route_used_q;
	logic [31:0] if_addr_q [INTERFACES];
	logic [INTERFACES-1:0] if_used_q;

	// Latched packet
	logic [31:0] addr_q;
	logic [7:0]  ttl_q, proto_q, itype_q;
	logic [15:0] plen_q;
	logic [1:0]  sums_q;

	// Scan state
	logic [IF_IDX_W-1:0] if_idx_q, if_hit_idx_q;
	logic [RT_IDX_W-1:0] rt_idx_q;
	logic                local_q, found_q;
	logic [31:0]         best_mask_q, best_gw_q;
	logic [1:0]          best_port_q;

	// Output register
	action_t     action_q;
	logic [1:0]  local_if_q, out_port_q;
	logic [31:0] next_hop_q;
	logic [7:0]  new_ttl_q;

	logic [7:0]          slot_ext;
	logic [RT_IDX_W-1:0] rt_wr_idx;
	logic [IF_IDX_W-1:0] if_wr_idx;
	logic                rt_wr_en, if_wr_en;
	logic                if_hit_now, rt_match, rt_better;
	logic                pre_ok, ttl_low;
	action_t             act_d;
	logic [1:0]          lif_d;

	assign slot_ext  = 8'(slot);
	assign rt_wr_idx = slot_ext[RT_IDX_W-1:0];
	assign if_wr_idx = slot_ext[IF_IDX_W-1:0];
	assign rt_wr_en  = cmd.capture && (op_t'(op) == OP_ROUTE)
		&& (9'(slot) < 9'(ROUTE_ENTRIES));
	assign if_wr_en  = cmd.capture && (op_t'(op) == OP_IFACE)
		&& (5'(slot) < 5'(INTERFACES));

	// Write route entries; removal clears only the used bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_used_q <= '0;
		end else if (rt_wr_en) begin
			route_used_q[rt_wr_idx] <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rt_wr_en && entry_valid) begin
			route_dest_q[rt_wr_idx] <= addr;
			route_mask_q[rt_wr_idx] <= prefix_mask;
			route_gw_q[rt_wr_idx]   <= gateway;
			route_port_q[rt_wr_idx] <= port;
		end
	end

	// Write interface addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if_used_q <= '0;
		end else if (if_wr_en) begin
			if_used_q[if_wr_idx] <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (if_wr_en && entry_valid) begin
			if_addr_q[if_wr_idx] <= addr;
		end
	end

	// Latch packet fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q  <= addr;
			ttl_q   <= ttl;
			proto_q <= protocol;
			itype_q <= icmp_kind;
			plen_q  <= packet_length;
			sums_q  <= sum_flags;
		end
	end

	// Compare the current entries
	assign if_hit_now = if_used_q[if_idx_q] && (if_addr_q[if_idx_q] == addr_q);
	assign rt_match   = route_used_q[rt_idx_q]
		&& (((addr_q ^ route_dest_q[rt_idx_q]) & route_mask_q[rt_idx_q]) == 32'd0);
	assign rt_better  = !found_q || (route_mask_q[rt_idx_q] > best_mask_q);

	// Advance the scans; keep the first local hit and the longest prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if_idx_q <= '0;
			rt_idx_q <= '0;
			local_q  <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.capture) begin
			if_idx_q <= '0;
			rt_idx_q <= '0;
			local_q  <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.if_step) begin
				if_idx_q <= if_idx_q + 1'b1;
				if (if_hit_now && !local_q) begin
					local_q <= 1'b1;
				end
			end
			if (cmd.rt_step) begin
				rt_idx_q <= rt_idx_q + 1'b1;
				if (rt_match && rt_better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.if_step && if_hit_now && !local_q) begin
			if_hit_idx_q <= if_idx_q;
		end
		if (cmd.rt_step && rt_match && rt_better) begin
			best_mask_q <= route_mask_q[rt_idx_q];
			best_gw_q   <= route_gw_q[rt_idx_q];
			best_port_q <= route_port_q[rt_idx_q];
		end
	end

	assign pre_ok  = (plen_q >= MIN_IP_LEN) && sums_q[0];
	assign ttl_low = (ttl_q <= 8'd1);

	// Status to the controller
	always_comb begin
		sts.classify = (op_t'(op) == OP_CLASSIFY);
		sts.pre_ok   = pre_ok;
		sts.is_local = local_q || (cmd.if_step && if_hit_now);
		sts.ttl_low  = ttl_low;
		sts.if_last  = (if_idx_q == IF_IDX_W'(INTERFACES - 1));
		sts.rt_last  = (rt_idx_q == RT_IDX_W'(ROUTE_ENTRIES - 1));
	end

	// Form the decision
	always_comb begin
		act_d = ACT_NONE;
		lif_d = 2'd0;
		if (pre_ok) begin
			if (local_q) begin
				if (proto_q == PROTO_ICMP) begin
					if ((plen_q >= MIN_ICMP_LEN) && sums_q[1]
						&& (itype_q == ICMP_ECHO_REQUEST)) begin
						act_d = ACT_ECHO;
						lif_d = 2'(if_hit_idx_q);
					end
				end else begin
					act_d = ACT_PORT_UNREACH;
					lif_d = 2'(if_hit_idx_q);
				end
			end else if (ttl_low) begin
				act_d = ACT_TIME_EXCEEDED;
			end else if (!found_q) begin
				act_d = ACT_NET_UNREACH;
			end else begin
				act_d = ACT_FORWARD;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			action_q   <= act_d;
			local_if_q <= lif_d;
			if (act_d == ACT_FORWARD) begin
				next_hop_q <= best_gw_q;
				out_port_q <= best_port_q;
				new_ttl_q  <= ttl_q - 8'd1;
			end else begin
				next_hop_q <= 32'd0;
				out_port_q <= 2'd0;
				new_ttl_q  <= ttl_q;
			end
		end
	end

	assign action   = action_q;
	assign local_if = local_if_q;
	assign next_hop = next_hop_q;
	assign out_port = out_port_q;
	assign new_ttl  = new_ttl_q;

endmodule

>>> sv/ipv4_forwarding_decision.sv
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision: longest prefix match forwarding decision
// Table writes give no result. A classify request steps through the interface table
// one entry a cycle, then through the route table unless that scan is skipped, and
// the decision is loaded into the output register once that register is free; the
// next request is accepted after the sequencer is back in idle.
// A finished result waits in the output register while the next request runs.
// Reset clears the used bits of both tables; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision
	import ipfwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [31:0] addr,
	input  logic [31:0] prefix_mask,
	input  logic [31:0] gateway,
	input  logic [1:0]  port,
	input  logic        entry_valid,
	input  logic [7:0]  ttl,
	input  logic [7:0]  protocol,
	input  logic [7:0]  icmp_kind,
	input  logic [15:0] packet_length,
	input  logic [1:0]  sum_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [1:0]  local_if,
	output logic [31:0] next_hop,
	output logic [1:0]  out_port,
	output logic [7:0]  new_ttl
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	ipfwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Tables, scans and decision
	ipfwd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.slot          (slot),
		.addr          (addr),
		.prefix_mask   (prefix_mask),
		.gateway       (gateway),
		.port          (port),
		.entry_valid   (entry_valid),
		.ttl           (ttl),
		.protocol      (protocol),
		.icmp_kind     (icmp_kind),
		.packet_length (packet_length),
		.sum_flags     (sum_flags),
		.action        (action),
		.local_if      (local_if),
		.next_hop      (next_hop),
		.out_port      (out_port),
		.new_ttl       (new_ttl)
	);

endmodule

>>> verif/ipv4_forwarding_decision_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_test: self-checking bench for the forwarding block
// Fills the route and interface tables and sends packet requests. A local
// copy of both tables works out each decision when the request is accepted.
// A monitor compares every decision field by field with the oldest one
// still waiting. Both sides idle at random, with one calm stretch, one long
// receiver stall and two sender pauses until all decisions are back.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_test;
	import ipfwd_pkg::*;

	localparam int RANDOM_REQUESTS = 1925;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int IDLE_PCT        = 27;
	localparam int CALM_FROM       = 500;
	localparam int CALM_TO         = 800;
	localparam int STALL_AT        = 1300;
	localparam int STALL_CYCLES    = 500;
	localparam int DRAIN_AT        = 900;
	localparam int TAIL_CYCLES     = 40;

	typedef struct {
		op_t         op;
		logic [3:0]  slot;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] gw;
		logic [1:0]  port;
		logic        keep;
		logic [7:0]  ttl;
		logic [7:0]  protocol;
		logic [7:0]  icmp_kind;
		logic [15:0] length;
		logic [1:0]  sums;
		bit          wait_drain;
	} request_t;

	typedef struct {
		action_t     act;
		logic [1:0]  lif;
		logic [31:0] hop;
		logic [1:0]  oport;
		logic [7:0]  ttl_out;
	} decision_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [3:0]  slot;
	logic [31:0] addr;
	logic [31:0] prefix_mask;
	logic [31:0] gateway;
	logic [1:0]  port;
	logic        entry_valid;
	logic [7:0]  ttl;
	logic [7:0]  protocol;
	logic [7:0]  icmp_kind;
	logic [15:0] packet_length;
	logic [1:0]  sum_flags;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  action;
	logic [1:0]  local_if;
	logic [31:0] next_hop;
	logic [1:0]  out_port;
	logic [7:0]  new_ttl;

	// Table copy used for prediction, updated as requests are accepted
	logic [31:0] fib_dest [ROUTE_ENTRIES];
	logic [31:0] fib_mask [ROUTE_ENTRIES];
	logic [31:0] fib_gw   [ROUTE_ENTRIES];
	logic [1:0]  fib_port [ROUTE_ENTRIES];
	bit          fib_live [ROUTE_ENTRIES];
	logic [31:0] iface_addr [INTERFACES];
	bit          iface_live [INTERFACES];

	// Table copy used while building stimulus, to aim packets at entries
	logic [31:0] plan_dest [ROUTE_ENTRIES];
	logic [31:0] plan_mask [ROUTE_ENTRIES];
	logic [31:0] plan_if   [INTERFACES];
	bit          plan_if_live [INTERFACES];

	request_t  request_queue [$];
	decision_t pending_decisions [$];
	request_t  offered;
	bit        req_fire;
	int        accepted_count;
	int        cycle_count;
	int        failures;
	int        stall_left;
	bit        stall_done;

	ipv4_forwarding_decision dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out the decision for one request and update the tables
	function automatic bit route_request(input request_t r, output decision_t d);
		bit         is_local;
		logic [1:0] hit;
		bit         found;
		int         best;
		d = '{ACT_NONE, 2'd0, 32'd0, 2'd0, r.ttl};
		case (r.op)
		OP_ROUTE: begin
			if (r.slot < ROUTE_ENTRIES) begin
				fib_live[r.slot] = r.keep;
				if (r.keep) begin
					fib_dest[r.slot] = r.addr;
					fib_mask[r.slot] = r.mask;
					fib_gw[r.slot]   = r.gw;
					fib_port[r.slot] = r.port;
				end
			end
			return 1'b0;
		end
		OP_IFACE: begin
			if (r.slot < INTERFACES) begin
				iface_live[r.slot] = r.keep;
				if (r.keep)
					iface_addr[r.slot] = r.addr;
			end
			return 1'b0;
		end
		OP_CLASSIFY: ;
		default: return 1'b0;
		endcase

		if (r.length >= MIN_IP_LEN && r.sums[0]) begin
			// scan downward so the lowest matching interface wins
			is_local = 1'b0;
			hit = 2'd0;
			for (int i = INTERFACES - 1; i >= 0; i--) begin
				if (iface_live[i] && iface_addr[i] == r.addr) begin
					is_local = 1'b1;
					hit = i[1:0];
				end
			end
			if (is_local) begin
				if (r.protocol == PROTO_ICMP) begin
					if (r.length >= MIN_ICMP_LEN && r.sums[1] &&
						r.icmp_kind == ICMP_ECHO_REQUEST) begin
						d.act = ACT_ECHO;
						d.lif = hit;
					end
				end else begin
					d.act = ACT_PORT_UNREACH;
					d.lif = hit;
				end
			end else if (r.ttl <= 8'd1) begin
				d.act = ACT_TIME_EXCEEDED;
			end else begin
				// longest prefix: largest mask value, lowest slot on a tie
				found = 1'b0;
				best = 0;
				for (int i = 0; i < ROUTE_ENTRIES; i++) begin
					if (fib_live[i] && ((r.addr ^ fib_dest[i]) & fib_mask[i]) == 32'd0 &&
						(!found || fib_mask[i] > fib_mask[best])) begin
						found = 1'b1;
						best = i;
					end
				end
				if (!found) begin
					d.act = ACT_NET_UNREACH;
				end else begin
					d.act     = ACT_FORWARD;
					d.hop     = fib_gw[best];
					d.oport   = fib_port[best];
					d.ttl_out = r.ttl - 8'd1;
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [31:0] prefix_to_mask(input int len);
		return (len == 0) ? 32'd0 : ~32'd0 << (32 - len);
	endfunction

	// Start from all fields random so unused fields toggle too
	function automatic request_t blank_request();
		request_t r;
		r.op         = OP_CLASSIFY;
		r.slot       = 4'($urandom);
		r.addr       = 32'($urandom);
		r.mask       = 32'($urandom);
		r.gw         = 32'($urandom);
		r.port       = 2'($urandom);
		r.keep       = 1'($urandom);
		r.ttl        = 8'($urandom);
		r.protocol   = 8'($urandom);
		r.icmp_kind  = 8'($urandom);
		r.length     = 16'($urandom);
		r.sums       = 2'($urandom);
		r.wait_drain = 1'b0;
		return r;
	endfunction

	function automatic request_t make_route(input logic [3:0] s, input logic [31:0] dest,
		input logic [31:0] m, input logic [31:0] g, input logic [1:0] p, input logic k);
		request_t r;
		r = blank_request();
		r.op   = OP_ROUTE;
		r.slot = s;
		r.addr = dest;
		r.mask = m;
		r.gw   = g;
		r.port = p;
		r.keep = k;
		return r;
	endfunction

	function automatic request_t make_iface(input logic [3:0] s, input logic [31:0] a,
		input logic k);
		request_t r;
		r = blank_request();
		r.op   = OP_IFACE;
		r.slot = s;
		r.addr = a;
		r.keep = k;
		return r;
	endfunction

	function automatic request_t make_packet(input logic [31:0] a, input logic [7:0] t,
		input logic [7:0] proto, input logic [7:0] itype, input logic [15:0] len,
		input logic [1:0] s);
		request_t r;
		r = blank_request();
		r.op        = OP_CLASSIFY;
		r.addr      = a;
		r.ttl       = t;
		r.protocol  = proto;
		r.icmp_kind = itype;
		r.length    = len;
		r.sums      = s;
		return r;
	endfunction

	// Queue a request and track table contents for later targeting
	task automatic add_request(input request_t r);
		if (r.op == OP_ROUTE && r.keep) begin
			plan_dest[r.slot] = r.addr;
			plan_mask[r.slot] = r.mask;
		end
		if (r.op == OP_IFACE && r.slot < INTERFACES) begin
			plan_if_live[r.slot] = r.keep;
			if (r.keep)
				plan_if[r.slot] = r.addr;
		end
		request_queue.push_back(r);
	endtask

	function automatic request_t random_request();
		request_t r;
		int       pick;
		int       idx;
		r = blank_request();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// route write, often nested under an existing prefix
			r.op = OP_ROUTE;
			r.keep = ($urandom_range(0, 99) < 85);
			r.mask = ($urandom_range(0, 99) < 85) ? prefix_to_mask($urandom_range(0, 32))
				: 32'($urandom);
			if ($urandom_range(0, 1) == 1) begin
				idx = $urandom_range(0, ROUTE_ENTRIES - 1);
				r.addr = (plan_dest[idx] & plan_mask[idx]) | (32'($urandom) & ~plan_mask[idx]);
			end
		end else if (pick < 15) begin
			r.op = OP_IFACE;
			r.keep = ($urandom_range(0, 99) < 85);
			if ($urandom_range(0, 99) < 85)
				r.slot = 4'($urandom_range(0, INTERFACES - 1));
		end else if (pick < 17) begin
			r.op = OP_UNUSED;
		end else begin
			r.op = OP_CLASSIFY;
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, INTERFACES - 1);
			if (pick < 25 && plan_if_live[idx]) begin
				r.addr = plan_if[idx];
			end else if (pick < 80) begin
				idx = $urandom_range(0, ROUTE_ENTRIES - 1);
				r.addr = (plan_dest[idx] & plan_mask[idx]) | (32'($urandom) & ~plan_mask[idx]);
			end
			case ($urandom_range(0, 9))
			0: r.ttl = 8'd0;
			1: r.ttl = 8'd1;
			2: r.ttl = 8'd2;
			3: r.ttl = 8'd255;
			default: ;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 45)
				r.protocol = PROTO_ICMP;
			else if (pick < 65)
				r.protocol = 8'd17;
			else if (pick < 75)
				r.protocol = 8'd6;
			if ($urandom_range(0, 99) < 60)
				r.icmp_kind = ICMP_ECHO_REQUEST;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				case ($urandom_range(0, 3))
				0: r.length = MIN_IP_LEN - 16'd1;
				1: r.length = MIN_IP_LEN;
				2: r.length = MIN_ICMP_LEN - 16'd1;
				default: r.length = MIN_ICMP_LEN;
				endcase
			end else if (pick >= 20) begin
				r.length = 16'($urandom_range(MIN_IP_LEN, 1514));
			end
			if ($urandom_range(0, 99) < 75)
				r.sums = 2'b11;
		end
		return r;
	endfunction

	// Stimulus, then wait for all decisions and report
	initial begin
		request_t r;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		out_ready     = 1'b0;
		op            = OP_CLASSIFY;
		slot          = '0;
		addr          = '0;
		prefix_mask   = '0;
		gateway       = '0;
		port          = '0;
		entry_valid   = 1'b0;
		ttl           = '0;
		protocol      = '0;
		icmp_kind     = '0;
		packet_length = '0;
		sum_flags     = '0;
		req_fire      = 1'b0;
		for (int i = 0; i < ROUTE_ENTRIES; i++) begin
			plan_dest[i] = '0;
			plan_mask[i] = '0;
		end
		for (int i = 0; i < INTERFACES; i++)
			plan_if[i] = '0;

		// empty tables: nothing to match
		add_request(make_packet(32'h0A01_0205, 8'd64, 8'd6, 8'd0, 16'd60, 2'b11));
		// interfaces: duplicate address, all-ones address, slot out of range
		add_request(make_iface(4'd0, 32'h0A00_0001, 1'b1));
		add_request(make_iface(4'd1, 32'h0A00_0001, 1'b1));
		add_request(make_iface(4'd3, 32'hFFFF_FFFF, 1'b1));
		add_request(make_iface(4'd9, 32'hC0A8_0101, 1'b1));
		// routes: default, nested prefixes, tied masks, host route, odd mask
		add_request(make_route(4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0A00_00FE, 2'd1, 1'b1));
		add_request(make_route(4'd1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 2'd2, 1'b1));
		add_request(make_route(4'd2, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_0201, 2'd3, 1'b1));
		add_request(make_route(4'd3, 32'h0A01_02FF, 32'hFFFF_FF00, 32'hDEAD_BEEF, 2'd0, 1'b1));
		add_request(make_route(4'd15, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1));
		add_request(make_route(4'd4, 32'h1200_3400, 32'hFF00_FF00, 32'h0102_0304, 2'd2, 1'b1));
		// forwarding paths
		add_request(make_packet(32'h12AB_34CD, 8'd255, 8'd6, 8'd0, 16'd1514, 2'b11));
		add_request(make_packet(32'h0A01_0203, 8'd2, 8'd17, 8'd0, MIN_IP_LEN, 2'b01));
		add_request(make_packet(32'hFFFF_FFFE, 8'd64, 8'd6, 8'd0, 16'hFFFF, 2'b11));
		// drops: short frame and bad header checksum
		add_request(make_packet(32'h0A01_0203, 8'd64, 8'd6, 8'd0, MIN_IP_LEN - 16'd1, 2'b11));
		add_request(make_packet(32'h0A01_0203, 8'd64, 8'd6, 8'd0, 16'd100, 2'b10));
		// local ICMP: echo, too short, bad ICMP checksum, other type
		add_request(make_packet(32'h0A00_0001, 8'd64, PROTO_ICMP, ICMP_ECHO_REQUEST,
			MIN_ICMP_LEN, 2'b11));
		add_request(make_packet(32'h0A00_0001, 8'd64, PROTO_ICMP, ICMP_ECHO_REQUEST,
			MIN_ICMP_LEN - 16'd1, 2'b11));
		add_request(make_packet(32'h0A00_0001, 8'd64, PROTO_ICMP, ICMP_ECHO_REQUEST,
			16'd98, 2'b01));
		add_request(make_packet(32'h0A00_0001, 8'd64, PROTO_ICMP, 8'd0, 16'd98, 2'b11));
		// local non-ICMP on the last interface, expiring ttl when not local
		add_request(make_packet(32'hFFFF_FFFF, 8'd1, 8'd17, 8'd0, 16'd80, 2'b11));
		add_request(make_packet(32'h0808_0808, 8'd0, 8'd17, 8'd0, 16'd80, 2'b11));
		// removals: the duplicate interface takes over, default route goes away
		add_request(make_iface(4'd0, 32'h0A00_0001, 1'b0));
		add_request(make_packet(32'h0A00_0001, 8'd64, 8'd6, 8'd0, 16'd80, 2'b11));
		add_request(make_route(4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0A00_00FE, 2'd1, 1'b0));
		add_request(make_packet(32'hC0A8_0101, 8'd64, 8'd6, 8'd0, 16'd80, 2'b11));
		r = blank_request();
		r.op = OP_UNUSED;
		add_request(r);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			r = random_request();
			if (n == 0 || n == DRAIN_AT)
				r.wait_drain = 1'b1;
			add_request(r);
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_decisions.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (failures == 0 && pending_decisions.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Drive requests on the falling edge, holding each until accepted
	always @(negedge clk) begin : drive_requests
		bit idle_now;
		bit blocked;
		request_t nxt;
		idle_now = !(accepted_count >= CALM_FROM && accepted_count < CALM_TO) &&
			($urandom_range(0, 99) < IDLE_PCT);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_fire) begin
			blocked = request_queue.size() == 0 ||
				(request_queue[0].wait_drain && pending_decisions.size() != 0);
			if (!blocked && !idle_now) begin
				nxt = request_queue.pop_front();
				offered = nxt;
				op            <= nxt.op;
				slot          <= nxt.slot;
				addr          <= nxt.addr;
				prefix_mask   <= nxt.mask;
				gateway       <= nxt.gw;
				port          <= nxt.port;
				entry_valid   <= nxt.keep;
				ttl           <= nxt.ttl;
				protocol      <= nxt.protocol;
				icmp_kind     <= nxt.icmp_kind;
				packet_length <= nxt.length;
				sum_flags     <= nxt.sums;
				in_valid      <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive the result ready: random stalls, one calm stretch, one long hold
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!stall_done && accepted_count >= STALL_AT) begin
			stall_left <= STALL_CYCLES;
			stall_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (accepted_count >= CALM_FROM && accepted_count < CALM_TO) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic flag_field(input string field, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $realtime, field, want_v, got_v);
			failures++;
		end
	endtask

	// Check decisions, then predict for the request accepted at this edge
	always @(posedge clk) begin : observe
		decision_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_decisions.size() == 0) begin
					$display("%0t: unexpected decision: expected none, actual action %0d",
						$realtime, action);
					failures++;
				end else begin
					want = pending_decisions.pop_front();
					flag_field("action", 32'(want.act), 32'(action));
					flag_field("local_if", 32'(want.lif), 32'(local_if));
					flag_field("next_hop", want.hop, next_hop);
					flag_field("out_port", 32'(want.oport), 32'(out_port));
					flag_field("new_ttl", 32'(want.ttl_out), 32'(new_ttl));
				end
			end
			req_fire = in_valid && in_ready;
			if (req_fire) begin
				accepted_count++;
				if (route_request(offered, want))
					pending_decisions.push_back(want);
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count == CYCLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

>>> filelist.f
sv/ipfwd_pkg.sv
sv/ipfwd_ctrl.sv
sv/ipfwd_dp.sv
sv/ipv4_forwarding_decision.sv
verif/ipv4_forwarding_decision_test.sv
